// File: hdl/sda_pkg.sv
// ---------------------------------------------------------------------------
// sda_pkg: shared types and constants of the scaled decimal alu
// Operation codes, controller states and the control word of the
// shift-add / shift-subtract unit.
// ---------------------------------------------------------------------------
package sda_pkg;

    localparam int VALUE_W             = 64;
    localparam int SCALE_IN_W          = 7;
    localparam int SCALE_OUT_W         = 9;
    localparam int DIV_PRESCALE_DIGITS = 8;
    localparam logic [VALUE_W-1:0] DIV_PRESCALE_FACTOR = 64'd100000000;
    localparam logic [VALUE_W-1:0] SIGN_BIT            = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] MAX_POS             = 64'h7FFF_FFFF_FFFF_FFFF;

    // operation codes
    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_CMP = 3'd4
    } mode_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ALIGN,
        ST_UNIT,
        ST_DIVGO,
        ST_FIN,
        ST_DONE
    } state_t;

    // control word for the serial unit
    typedef struct packed {
        logic start;
        logic is_div;
    } unit_ctl_t;

endpackage

// File: hdl/scaled_decimal_alu.sv
// ---------------------------------------------------------------------------
// scaled_decimal_alu: arithmetic on scaled decimals
// Add, subtract, multiply, divide and compare of value * 10^-scale numbers.
// ---------------------------------------------------------------------------
// Usage: one operand word enters on the s_axis channel (s_tvalid/s_tready),
// one result word leaves on the m_axis channel (m_tvalid/m_tready) for each.
// One item is processed at a time; s_tready is high while the controller
// is idle, also while a finished result still waits in the output register.
// Work from accept to m_tvalid, per mode:
//   add, subtract, compare: |a_scale - b_scale| multiplies by ten, one per
//     cycle during operand alignment, then the add, subtract or compare
//   multiply: the 64-step shift-add unit
//   divide: a 64-step prescale multiply followed by a
//     64-step restoring divide in the same serial unit; no divide on a zero divisor
//   unused mode: all fields zero
// Without stalls a new word can be taken in the cycle after the result loads.
// A stalled receiver holds the result in the output register; a second
// result then waits in the controller until the register frees up.
// Reset (rst_n low) empties the block; no result is pending afterward.
// ---------------------------------------------------------------------------
module scaled_decimal_alu
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[2:0], a_value[66:3], a_scale[73:67], b_value[137:74],
    // b_scale[144:138], zero fill[151:145]
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_value[63:0], result_scale[72:64], order[74:73], overflow[75],
    // divide_by_zero[76], zero fill[79:77]
    output logic [79:0]  m_tdata
);
    import sda_pkg::*;

    state_t state_reg, state_next;

    logic [2:0]             mode_reg;
    logic [VALUE_W-1:0]     av_reg, bv_reg;
    logic [SCALE_IN_W-1:0]  as_reg, bs_reg;
    logic [VALUE_W-1:0]     x_reg, y_reg, val_reg;
    logic                   ov_reg, dz_reg, neg_reg, phase_reg, scale_a_reg;
    logic [1:0]             ord_reg;
    logic [6:0]             cnt_reg;

    logic [VALUE_W-1:0]     out_val_reg;
    logic [SCALE_OUT_W-1:0] out_scale_reg;
    logic [1:0]             out_ord_reg;
    logic                   out_ov_reg, out_dz_reg, out_valid_reg;

    unit_ctl_t              uctl;
    logic [VALUE_W-1:0]     u_a, u_b, u_hi, u_lo;
    logic                   u_done;

    logic                   accept, load_out;
    logic [7:0]             sdiff;
    logic [VALUE_W-1:0]     av_mag, bv_mag, x_mag;
    logic [VALUE_W-1:0]     step_v, prod_signed;
    logic [VALUE_W+3:0]     step_ext, step_p;
    logic                   step_ov, prod_ov;
    logic [VALUE_W-1:0]     sum_r, dif_r;
    logic [SCALE_OUT_W-1:0] as9, bs9, scale_res;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // magnitudes and scale difference
    always_comb
    begin
        av_mag = av_reg[VALUE_W-1] ? (~av_reg + 64'd1) : av_reg;
        bv_mag = bv_reg[VALUE_W-1] ? (~bv_reg + 64'd1) : bv_reg;
        x_mag  = x_reg[VALUE_W-1] ? (~x_reg + 64'd1) : x_reg;
        sdiff  = {as_reg[SCALE_IN_W-1], as_reg} - {bs_reg[SCALE_IN_W-1], bs_reg};
    end

    // multiply by ten for alignment
    always_comb
    begin
        step_v   = scale_a_reg ? x_reg : y_reg;
        step_ext = {{4{step_v[VALUE_W-1]}}, step_v};
        step_p   = (step_ext << 3) + (step_ext << 1);
        step_ov  = !((step_p[VALUE_W+3:VALUE_W-1] == 5'b00000) ||
                     (step_p[VALUE_W+3:VALUE_W-1] == 5'b11111));
    end

    // product sign fix and fit check, sum and difference
    always_comb
    begin
        prod_signed = neg_reg ? (~u_lo + 64'd1) : u_lo;
        prod_ov     = (u_hi != '0) || (u_lo > (neg_reg ? SIGN_BIT : MAX_POS));
        sum_r       = x_reg + y_reg;
        dif_r       = x_reg - y_reg;
    end

    // result scale per mode
    always_comb
    begin
        as9 = {{2{as_reg[SCALE_IN_W-1]}}, as_reg};
        bs9 = {{2{bs_reg[SCALE_IN_W-1]}}, bs_reg};
        unique case (mode_reg)
            MODE_ADD, MODE_SUB, MODE_CMP:
                scale_res = ($signed(as9) > $signed(bs9)) ? as9 : bs9;
            MODE_MUL:
                scale_res = as9 + bs9;
            MODE_DIV:
                scale_res = as9 + SCALE_OUT_W'(DIV_PRESCALE_DIGITS) - bs9;
            default:
                scale_res = '0;
        endcase
    end

    // next state and unit control
    always_comb
    begin
        state_next  = state_reg;
        uctl.start  = 1'b0;
        uctl.is_div = 1'b0;
        u_a         = av_mag;
        u_b         = bv_mag;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                unique case (mode_reg)
                    MODE_ADD, MODE_SUB, MODE_CMP:
                        state_next = (sdiff == 8'd0) ? ST_FIN : ST_ALIGN;
                    MODE_MUL:
                    begin
                        uctl.start = 1'b1;
                        state_next = ST_UNIT;
                    end
                    MODE_DIV:
                    begin
                        uctl.start = 1'b1;
                        u_b        = DIV_PRESCALE_FACTOR;
                        state_next = ST_UNIT;
                    end
                    default:
                        state_next = ST_FIN;
                endcase
            end
            ST_ALIGN:
            begin
                if (cnt_reg == 7'd1)
                    state_next = ST_FIN;
            end
            ST_UNIT:
            begin
                if (u_done)
                begin
                    if (mode_reg == MODE_DIV && !phase_reg && bv_reg != '0)
                        state_next = ST_DIVGO;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_DIVGO:
            begin
                uctl.start  = 1'b1;
                uctl.is_div = 1'b1;
                u_a         = x_mag;
                state_next  = ST_UNIT;
            end
            ST_FIN:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= s_tdata[2:0];
            av_reg   <= s_tdata[66:3];
            as_reg   <= s_tdata[73:67];
            bv_reg   <= s_tdata[137:74];
            bs_reg   <= s_tdata[144:138];
        end
        unique case (state_reg)
            ST_SETUP:
            begin
                x_reg       <= av_reg;
                y_reg       <= bv_reg;
                val_reg     <= '0;
                ov_reg      <= 1'b0;
                dz_reg      <= 1'b0;
                ord_reg     <= 2'b00;
                phase_reg   <= 1'b0;
                scale_a_reg <= sdiff[7];
                cnt_reg     <= sdiff[7] ? 7'(~sdiff + 8'd1) : sdiff[6:0];
                neg_reg     <= (mode_reg == MODE_MUL) ?
                               (av_reg[VALUE_W-1] ^ bv_reg[VALUE_W-1]) :
                               av_reg[VALUE_W-1];
            end
            ST_ALIGN:
            begin
                if (scale_a_reg)
                    x_reg <= step_p[VALUE_W-1:0];
                else
                    y_reg <= step_p[VALUE_W-1:0];
                ov_reg  <= ov_reg | step_ov;
                cnt_reg <= cnt_reg - 7'd1;
            end
            ST_UNIT:
            begin
                if (u_done)
                begin
                    if (mode_reg == MODE_MUL)
                    begin
                        val_reg <= prod_signed;
                        ov_reg  <= ov_reg | prod_ov;
                    end
                    else if (!phase_reg)
                    begin
                        // prescaled numerator
                        x_reg     <= prod_signed;
                        ov_reg    <= ov_reg | prod_ov;
                        phase_reg <= 1'b1;
                        dz_reg    <= (bv_reg == '0);
                        val_reg   <= '0;
                    end
                    else
                    begin
                        // quotient with sign
                        val_reg <= neg_reg ? (~u_lo + 64'd1) : u_lo;
                        ov_reg  <= ov_reg | (!neg_reg && u_lo[VALUE_W-1]);
                    end
                end
            end
            ST_DIVGO:
                neg_reg <= x_reg[VALUE_W-1] ^ bv_reg[VALUE_W-1];
            ST_FIN:
            begin
                unique case (mode_reg)
                    MODE_ADD:
                    begin
                        val_reg <= sum_r;
                        ov_reg  <= ov_reg |
                                   ((x_reg[63] ^ sum_r[63]) & (y_reg[63] ^ sum_r[63]));
                    end
                    MODE_SUB:
                    begin
                        val_reg <= dif_r;
                        ov_reg  <= ov_reg |
                                   ((x_reg[63] ^ y_reg[63]) & (x_reg[63] ^ dif_r[63]));
                    end
                    MODE_CMP:
                    begin
                        if ($signed(x_reg) < $signed(y_reg))
                            ord_reg <= 2'b11;
                        else if ($signed(x_reg) > $signed(y_reg))
                            ord_reg <= 2'b01;
                        else
                            ord_reg <= 2'b00;
                    end
                    default:
                    begin
                        val_reg <= '0;
                        ov_reg  <= 1'b0;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_val_reg   <= val_reg;
            out_scale_reg <= scale_res;
            out_ord_reg   <= ord_reg;
            out_ov_reg    <= ov_reg;
            out_dz_reg    <= dz_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_dz_reg, out_ov_reg, out_ord_reg,
                       out_scale_reg, out_val_reg};

    // shared serial multiply / divide unit
    sda_unit u_unit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (uctl),
        .op_a  (u_a),
        .op_b  (u_b),
        .done  (u_done),
        .hi    (u_hi),
        .lo    (u_lo)
    );

endmodule

// File: hdl/sda_unit.sv
// ---------------------------------------------------------------------------
// sda_unit: bit-serial multiply / divide unit
// Radix-2 shift-add multiply (128-bit product in hi:lo) or restoring
// unsigned divide (quotient in lo), one bit per cycle.
// ---------------------------------------------------------------------------
module sda_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  sda_pkg::unit_ctl_t                ctl,
    input  logic [sda_pkg::VALUE_W-1:0]       op_a,  // multiplier or dividend
    input  logic [sda_pkg::VALUE_W-1:0]       op_b,  // multiplicand or divisor
    output logic                              done,
    output logic [sda_pkg::VALUE_W-1:0]       hi,
    output logic [sda_pkg::VALUE_W-1:0]       lo
);
    import sda_pkg::*;

    logic [VALUE_W-1:0] a_reg, a_next;
    logic [VALUE_W-1:0] h_reg, h_next;
    logic [VALUE_W-1:0] b_reg;
    logic               div_reg;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [VALUE_W:0]   sum;
    logic [VALUE_W+1:0] trial;

    // one step of the shared datapath
    always_comb
    begin
        sum   = {1'b0, h_reg} + (a_reg[0] ? {1'b0, b_reg} : {(VALUE_W+1){1'b0}});
        trial = {1'b0, h_reg, a_reg[VALUE_W-1]} - {2'b00, b_reg};
        a_next    = a_reg;
        h_next    = h_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            a_next    = op_a;
            h_next    = '0;
            cnt_next  = 6'd63;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (!trial[VALUE_W+1])
                begin
                    h_next = trial[VALUE_W-1:0];
                    a_next = {a_reg[VALUE_W-2:0], 1'b1};
                end
                else
                begin
                    h_next = {h_reg[VALUE_W-2:0], a_reg[VALUE_W-1]};
                    a_next = {a_reg[VALUE_W-2:0], 1'b0};
                end
            end
            else
            begin
                h_next = sum[VALUE_W:1];
                a_next = {sum[0], a_reg[VALUE_W-1:1]};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        h_reg <= h_next;
        if (ctl.start)
        begin
            b_reg   <= op_b;
            div_reg <= ctl.is_div;
        end
    end

    assign done = done_reg;
    assign hi   = h_reg;
    assign lo   = a_reg;

endmodule
